// ===== rtl/f16lm_pkg.sv =====
// f16lm_pkg: shared types, constants and the distributed-arithmetic table
// for the 16-tap FIR level meter. Depends on nothing; used by every rtl file but f16lm_chk.
`default_nettype none

package f16lm_pkg;

  localparam int TAP_COUNT  = 16;
  localparam int PAIR_COUNT = TAP_COUNT / 2;
  localparam int SAMPLE_W   = 16;
  localparam int PAIR_W     = SAMPLE_W + 1;       // symmetric pre-add grows one bit
  localparam int COEF_W     = 13;
  localparam int DA_W       = 15;                 // sum of all eight coefficients < 2^15
  localparam int SUM_W      = 32;
  localparam int LEVEL_W    = 4;
  localparam int LAMP_W     = 16;
  localparam int LVL_SHIFT  = 27;                 // level = |sum| / 2^27
  localparam int CNT_W      = 5;                  // counts the PAIR_W bit steps

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd15;

  // first half of the symmetric coefficient set, newest tap first
  localparam logic [COEF_W-1:0] TAP_COEF [PAIR_COUNT] = '{
    13'd2086, 13'd2676, 13'd3312, 13'd3957,
    13'd4562, 13'd5075, 13'd5449, 13'd5647
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  // sequencer controls for the history / pre-add and accumulator units
  typedef struct packed {
    logic load;    // new sample taken: shift history, load pair registers
    logic step;    // one bit step of the serial product
    logic first;   // step on the sign bit
  } ctl_t;

  // Distributed-arithmetic table: sum of the coefficients whose pair bit is set.
  function automatic logic [DA_W-1:0] da_sum(input logic [PAIR_COUNT-1:0] sel);
    logic [DA_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < PAIR_COUNT; k++) begin
      if (sel[k]) begin
        acc = acc + DA_W'(TAP_COEF[k]);
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/f16lm_hist.sv =====
// f16lm_hist: sample history line, symmetric pre-adders and the pair shift
// registers that feed the serial product one bit column per cycle. Uses f16lm_pkg.
`default_nettype none

module f16lm_hist (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire f16lm_pkg::ctl_t                        ctl,
  input  wire logic signed [f16lm_pkg::SAMPLE_W-1:0]  sample,
  output logic         [f16lm_pkg::PAIR_COUNT-1:0]    digit
);

  logic signed [f16lm_pkg::SAMPLE_W-1:0] hist [f16lm_pkg::TAP_COUNT];
  logic signed [f16lm_pkg::SAMPLE_W-1:0] taps [f16lm_pkg::TAP_COUNT];
  logic        [f16lm_pkg::PAIR_W-1:0]   pair [f16lm_pkg::PAIR_COUNT];

  // history as it stands once the new sample is in (index = age)
  always_comb begin
    taps[0] = sample;
    for (int i = 1; i < f16lm_pkg::TAP_COUNT; i++) begin
      taps[i] = hist[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < f16lm_pkg::TAP_COUNT; i++) begin
        hist[i] <= '0;
      end
    end else if (ctl.load) begin
      for (int i = 0; i < f16lm_pkg::TAP_COUNT; i++) begin
        hist[i] <= taps[i];
      end
    end
  end

  // pairs shift MSB first
  always_ff @(posedge clk) begin
    for (int k = 0; k < f16lm_pkg::PAIR_COUNT; k++) begin
      if (ctl.load) begin
        pair[k] <= f16lm_pkg::PAIR_W'(
          {taps[k][f16lm_pkg::SAMPLE_W-1], taps[k]} +
          {taps[f16lm_pkg::TAP_COUNT-1-k][f16lm_pkg::SAMPLE_W-1],
           taps[f16lm_pkg::TAP_COUNT-1-k]});
      end else if (ctl.step) begin
        pair[k] <= {pair[k][f16lm_pkg::PAIR_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < f16lm_pkg::PAIR_COUNT; k++) begin
      digit[k] = pair[k][f16lm_pkg::PAIR_W-1];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/f16lm_dacc.sv =====
// f16lm_dacc: table lookup and shift-accumulate of the bit-serial FIR product.
// Uses f16lm_pkg (da_sum table, widths, ctl_t).
`default_nettype none

module f16lm_dacc (
  input  wire logic                               clk,
  input  wire f16lm_pkg::ctl_t                    ctl,
  input  wire logic [f16lm_pkg::PAIR_COUNT-1:0]   digit,
  output logic      [f16lm_pkg::SUM_W-1:0]        acc
);

  logic [f16lm_pkg::DA_W-1:0]  part;
  logic [f16lm_pkg::SUM_W-1:0] part_ext;
  logic [f16lm_pkg::SUM_W-1:0] acc_next;

  always_comb begin
    part     = f16lm_pkg::da_sum(digit);
    part_ext = {{(f16lm_pkg::SUM_W-f16lm_pkg::DA_W){1'b0}}, part};
    // sign column carries negative weight
    if (ctl.first) begin
      acc_next = '0 - part_ext;
    end else begin
      acc_next = {acc[f16lm_pkg::SUM_W-2:0], 1'b0} + part_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/f16lm_level.sv =====
// f16lm_level: output register with magnitude level and lamp decode.
// Uses f16lm_pkg constants.
`default_nettype none

module f16lm_level (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  wire logic [f16lm_pkg::SUM_W-1:0]       acc,
  input  wire logic                              taken,
  output logic                                   valid,
  output logic      [f16lm_pkg::SUM_W-1:0]       sum,
  output logic      [f16lm_pkg::LEVEL_W-1:0]     level,
  output logic      [f16lm_pkg::LAMP_W-1:0]      lamp
);

  localparam int QW = f16lm_pkg::SUM_W - f16lm_pkg::LVL_SHIFT;

  logic [f16lm_pkg::SUM_W-1:0]   mag;
  logic [QW-1:0]                 quot;
  logic [f16lm_pkg::LEVEL_W-1:0] level_next;

  always_comb begin
    mag  = acc[f16lm_pkg::SUM_W-1] ? ('0 - acc) : acc;
    quot = mag[f16lm_pkg::SUM_W-1:f16lm_pkg::LVL_SHIFT];
    if (quot > QW'(f16lm_pkg::LEVEL_MAX)) begin
      level_next = f16lm_pkg::LEVEL_MAX;
    end else begin
      level_next = quot[f16lm_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (taken) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum   <= acc;
      level <= level_next;
      lamp  <= ~(f16lm_pkg::LAMP_W'(1) << level_next);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fir16_level_meter.sv =====
// fir16_level_meter: top level of the 16-tap symmetric FIR with level meter.
// Instantiates f16lm_hist, f16lm_dacc, f16lm_level; uses f16lm_pkg.
//
// One signed 16-bit sample per input transaction. The last 16 samples (zero
// after reset) are filtered with a fixed symmetric low-pass kernel, newest
// sample on the first coefficient. The product runs as distributed arithmetic:
// the eight symmetric pairs are pre-added into 17-bit words, then shifted out
// MSB first one bit column per cycle into a 256-entry coefficient-sum table
// and a shift accumulator. An item passes through an accept/pre-add step,
// 17 bit steps (one per pre-added bit) and a load of the output register
// before the next ready, so a new sample waits until the last is loaded.
// The output register lets the next sample be accepted while a result
// still waits; the block stalls in its load step only if the
// previous result has not yet been taken. Each result carries the 32-bit sum,
// the level |sum| / 2^27 clamped to 15, and an active-low lamp pattern with
// only the level's bit low.
`default_nettype none

module fir16_level_meter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [55:0] m_tdata    // [31:0] filtered_sum, [35:32] magnitude_level,
                                      // [51:36] lamp_pattern, [55:52] zero
);

  f16lm_pkg::state_t state, state_next;
  f16lm_pkg::ctl_t   ctl;

  logic [f16lm_pkg::CNT_W-1:0]      cnt;
  logic                             last_step;
  logic                             out_load;
  logic [f16lm_pkg::PAIR_COUNT-1:0] digit;
  logic [f16lm_pkg::SUM_W-1:0]      acc;
  logic [f16lm_pkg::SUM_W-1:0]      sum;
  logic [f16lm_pkg::LEVEL_W-1:0]    level;
  logic [f16lm_pkg::LAMP_W-1:0]     lamp;

  assign last_step = (cnt == f16lm_pkg::CNT_W'(f16lm_pkg::PAIR_W - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      f16lm_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = f16lm_pkg::ST_CALC;
        end
      end
      f16lm_pkg::ST_CALC: begin
        if (last_step) begin
          state_next = f16lm_pkg::ST_DONE;
        end
      end
      f16lm_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = f16lm_pkg::ST_IDLE;
        end
      end
      default: state_next = f16lm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer; no transaction is taken while in reset
  always_comb begin
    s_tready  = 1'b0;
    ctl       = '0;
    out_load  = 1'b0;
    unique case (state)
      f16lm_pkg::ST_IDLE: begin
        s_tready = !rst;
        ctl.load = s_tvalid && !rst;
      end
      f16lm_pkg::ST_CALC: begin
        ctl.step  = 1'b1;
        ctl.first = (cnt == '0);
      end
      f16lm_pkg::ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= f16lm_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        cnt <= '0;
      end else if (ctl.step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  f16lm_hist u_hist (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (s_tdata),
    .digit  (digit)
  );

  f16lm_dacc u_dacc (
    .clk   (clk),
    .ctl   (ctl),
    .digit (digit),
    .acc   (acc)
  );

  f16lm_level u_level (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .acc   (acc),
    .taken (m_tready),
    .valid (m_tvalid),
    .sum   (sum),
    .level (level),
    .lamp  (lamp)
  );

  assign m_tdata = {4'b0000, lamp, level, sum};

endmodule

`default_nettype wire

// ===== rtl/f16lm_chk.sv =====
// f16lm_chk: port-level checker for fir16_level_meter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module f16lm_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [15:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata
);

  logic [31:0] sum;
  logic [31:0] mag;
  logic [3:0]  exp_level;

  always_comb begin
    sum       = m_tdata[31:0];
    mag       = sum[31] ? ('0 - sum) : sum;
    exp_level = (mag[31:27] > 5'd15) ? 4'd15 : mag[30:27];
  end

  // the serial product must finish first: no back-to-back acceptance
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sample accepted on consecutive cycles");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid |-> !$isunknown(s_tdata))
    else $error("offered sample has unknown bits");

  a_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[35:32] == exp_level))
    else $error("level does not match filtered sum");

  a_lamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[51:36] == ~(16'd1 << m_tdata[35:32])))
    else $error("lamp pattern does not match level");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind fir16_level_meter f16lm_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/fir16_level_checker.sv =====
// fir16_level_checker: watches both stream channels of fir16_level_meter,
// predicts each result from its own copy of the sample history and compares.
// Standalone; no package or rtl dependency.
module fir16_level_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [55:0] m_tdata,   // [31:0] sum, [35:32] level, [51:36] lamps
  output int               pending,
  output int               mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS        = 16;
  localparam int LEVEL_SHIFT = 27;
  localparam int LEVEL_TOP   = 15;

  typedef struct packed {
    logic [15:0] lamps;
    logic [3:0]  level;
    logic [31:0] fsum;
  } meter_result_t;

  logic signed [15:0] sample_ring [TAPS];
  logic [3:0]         next_slot;
  meter_result_t      meter_expect_q [$];
  int                 err_total;

  // symmetric kernel, age 0 = newest sample
  function automatic int kernel_weight(input int age);
    case ((age > 7) ? (TAPS - 1 - age) : age)
      0: return 2086;
      1: return 2676;
      2: return 3312;
      3: return 3957;
      4: return 4562;
      5: return 5075;
      6: return 5449;
      default: return 5647;
    endcase
  endfunction

  // push the sample into the ring and return the filter/meter outputs
  function automatic meter_result_t filter_sample(input logic [15:0] raw);
    meter_result_t res;
    longint acc;
    longint tap_val;
    longint mag;
    int lvl;
    sample_ring[next_slot] = raw;
    acc = 0;
    for (int age = 0; age < TAPS; age++) begin
      tap_val = sample_ring[4'(next_slot - age)];
      acc += kernel_weight(age) * tap_val;
    end
    next_slot = next_slot + 4'd1;
    mag = (acc < 0) ? -acc : acc;
    lvl = int'(mag >> LEVEL_SHIFT);
    if (lvl > LEVEL_TOP) begin
      lvl = LEVEL_TOP;
    end
    res.fsum  = acc[31:0];
    res.level = 4'(lvl);
    res.lamps = ~(16'h0001 << lvl);
    return res;
  endfunction

  initial begin
    pending    = 0;
    mismatches = 0;
    err_total  = 0;
  end

  always @(posedge clk) begin : watch
    meter_result_t want;
    meter_result_t got;
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        sample_ring[k] = '0;
      end
      next_slot = '0;
      meter_expect_q.delete();
    end else begin
      // results first: a result leaving now never belongs to a sample entering now
      if (m_tvalid && m_tready) begin
        got = m_tdata[51:0];
        if (m_tdata[55:52] != 4'h0) begin
          $display("%0t: pad bits expected 0 actual %h", $time, m_tdata[55:52]);
          err_total++;
        end
        if (meter_expect_q.size() == 0) begin
          $display("%0t: unexpected result sum %h level %0d lamps %h",
                   $time, got.fsum, got.level, got.lamps);
          err_total++;
        end else begin
          want = meter_expect_q.pop_front();
          if (got.fsum !== want.fsum) begin
            $display("%0t: filtered_sum expected %0d actual %0d", $time,
                     $signed(want.fsum), $signed(got.fsum));
            err_total++;
          end
          if (got.level !== want.level) begin
            $display("%0t: magnitude_level expected %0d actual %0d", $time,
                     want.level, got.level);
            err_total++;
          end
          if (got.lamps !== want.lamps) begin
            $display("%0t: lamp_pattern expected %h actual %h", $time,
                     want.lamps, got.lamps);
            err_total++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        meter_expect_q.push_back(filter_sample(s_tdata));
      end
    end
    pending    <= meter_expect_q.size();
    mismatches <= err_total;
  end

endmodule

// ===== dv/testbench.sv =====
// testbench: stimulus and verdict for fir16_level_meter.
// Instantiates the block and fir16_level_checker, which checks every result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES   = 40;    // idle cycles before the final verdict
  localparam int PHASE_ITEMS    = 338;   // four idling phases, ~1350 random samples

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  int pending;
  int mismatches;
  int idle_cycles = 0;
  int src_idle_pct = 0;   // chance per sample of an idle cycle before it
  int snk_stall_pct = 0;  // chance per cycle of m_tready low

  fir16_level_meter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  fir16_level_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: back-pressure drawn fresh every cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: a healthy run never goes this long without a transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Saturate to the signed 16-bit sample range.
  function automatic logic [15:0] sat16(input int v);
    if (v > 32767) begin
      return 16'h7fff;
    end
    if (v < -32768) begin
      return 16'h8000;
    end
    return 16'(v);
  endfunction

  // One sample transaction. tvalid is left high on return so back-to-back
  // samples need no dead cycle; an idle draw in the next call or a drain lowers it.
  task automatic send_sample(input logic [15:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold the sender off until every predicted result has been taken.
  // Wait one edge first so the count includes the last accepted sample.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random traffic: half the runs steady and long enough to fill the history, so
  // the level sweeps the whole 0..15 range; plus white noise, rail hopping
  // and small-signal stretches.
  task automatic random_phase(input int n_items);
    int sent;
    int kind;
    int run_len;
    int amp;
    sent = 0;
    while (sent < n_items) begin
      kind    = $urandom_range(9);
      run_len = $urandom_range(4, 16);
      amp     = $urandom_range(32767);
      if ($urandom_range(1) == 1) begin
        amp = -amp - 1;
      end
      if (kind < 5) begin
        run_len = $urandom_range(16, 28);
      end
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        case (kind)
          0, 1, 2, 3, 4: send_sample(sat16(amp + $urandom_range(63) - 32));
          5, 6:          send_sample(16'($urandom_range(65535)));
          7: begin
            case ($urandom_range(3))
              0: send_sample(16'h7fff);
              1: send_sample(16'h8000);
              2: send_sample(16'h0000);
              default: send_sample(16'hffff);
            endcase
          end
          default:       send_sample(sat16($urandom_range(511) - 256));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: negative rail fills the history from empty and wraps the
    // slot index, hitting the largest magnitude (level 15); the
    // positive rail then mixes in, and a zero closes.
    for (int k = 0; k < 16; k++) begin
      send_sample(16'h8000);
    end
    for (int k = 0; k < 8; k++) begin
      send_sample(16'h7fff);
    end
    send_sample(16'h0000);
    drain_results();

    // Idling phases: none, sender only, receiver only, both lightly.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
        default: begin src_idle_pct = 7; snk_stall_pct = 7; end
      endcase
      random_phase(PHASE_ITEMS);
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
